/* src/assert_macros.svh */
// Assertion macros shared by the resampler RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIR_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define LIR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lir_pkg.sv */
// Package for the linear interpolation stereo resampler: payload types,
// fixed widths, phase and gain constants. No dependencies.
`default_nettype none

package lir_pkg;

	// Field and phase widths fixed by the payload and register formats
	localparam int SAMPLE_BITS     = 24;
	localparam int PHASE_FRAC_BITS = 32;
	localparam int PHASE_BITS      = PHASE_FRAC_BITS + 3;
	localparam int FRAC_BITS       = 16;
	localparam int GAIN_BITS       = 7;
	localparam int GAIN_DIVISOR    = 100;

	// Gain product magnitude: |sample| <= 2^(SAMPLE_BITS-1), gain < 2^GAIN_BITS
	localparam int MAG_BITS   = SAMPLE_BITS - 1 + GAIN_BITS;
	// Reciprocal of the divisor scaled by 2^MAG_BITS; divisor >= 64 drops 6 bits
	localparam int RECIP_BITS = MAG_BITS - 6;
	localparam logic [RECIP_BITS-1:0] RECIP =
		RECIP_BITS'((64'd1 << MAG_BITS) / GAIN_DIVISOR);

	// Lane pipeline depth, from held inputs to registered result
	localparam int LANE_LAT = 5;

	localparam logic [PHASE_BITS-1:0] PHASE_ONE = PHASE_BITS'(1) << PHASE_FRAC_BITS;
	localparam logic [PHASE_BITS-1:0] PHASE_MAX = '1;
	localparam logic [PHASE_BITS-1:0] STEP_RESET = PHASE_ONE;
	localparam logic [GAIN_BITS-1:0]  GAIN_RESET = GAIN_BITS'(GAIN_DIVISOR);

	// Configuration register indexes
	localparam logic CFG_PHASE_STEP = 1'b0;
	localparam logic CFG_GAIN       = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_in;
		logic signed [SAMPLE_BITS-1:0] right_in;
	} lir_in_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_out;
		logic signed [SAMPLE_BITS-1:0] right_out;
		logic                          run_end;
	} lir_out_t;

	// Load request from the sequencer into the merge register
	typedef struct packed {
		logic load;
		logic run_end;
	} lir_merge_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_WAIT
	} lir_state_t;

endpackage

`default_nettype wire

/* src/lir_lane.sv */
// One channel lane: linear interpolation between two frames, gain scaling,
// truncating divide by 100 and saturation. Depends on lir_pkg.
`default_nettype none

module lir_lane (
	input  logic                                  clk,
	input  logic signed [lir_pkg::SAMPLE_BITS-1:0] older,
	input  logic signed [lir_pkg::SAMPLE_BITS-1:0] newer,
	input  logic        [lir_pkg::FRAC_BITS-1:0]   frac,
	input  logic        [lir_pkg::GAIN_BITS-1:0]   gain,
	output logic signed [lir_pkg::SAMPLE_BITS-1:0] result
);
	import lir_pkg::*;

	localparam int PW = SAMPLE_BITS + FRAC_BITS + 2;
	localparam int QB = RECIP_BITS + 1;
	localparam logic [MAG_BITS-1:0] DIV_M = MAG_BITS'(GAIN_DIVISOR);
	localparam logic [QB-1:0] POS_MAX = QB'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
	localparam logic [QB-1:0] NEG_MAG = QB'(64'd1 << (SAMPLE_BITS - 1));
	localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [SAMPLE_BITS:0]     diff;
	logic signed [FRAC_BITS:0]       frac_se;
	logic signed [PW-1:0]            prod_s1;
	logic signed [SAMPLE_BITS-1:0]   older_s1;
	logic signed [PW-1:0]            sum;
	logic signed [SAMPLE_BITS-1:0]   v_s2;
	logic        [SAMPLE_BITS-1:0]   mag;
	logic        [SAMPLE_BITS+GAIN_BITS-1:0] mprod;
	logic        [MAG_BITS-1:0]      m_s3;
	logic                            neg_s3;
	logic        [MAG_BITS+RECIP_BITS-1:0] rprod;
	logic        [RECIP_BITS-1:0]    q0_s4;
	logic        [MAG_BITS-1:0]      m_s4;
	logic                            neg_s4;
	logic        [MAG_BITS-1:0]      qm;
	logic        [MAG_BITS-1:0]      rem;
	logic        [QB-1:0]            q;
	logic        [QB-1:0]            q_neg;

	// Stage 1: difference times fraction
	assign diff    = $signed({newer[SAMPLE_BITS-1], newer}) -
	                 $signed({older[SAMPLE_BITS-1], older});
	assign frac_se = $signed({1'b0, frac});

	always_ff @(posedge clk) begin
		prod_s1  <= diff * frac_se;
		older_s1 <= older;
	end

	// Stage 2: floor shift and add back the older frame
	assign sum = $signed({{(PW-SAMPLE_BITS){older_s1[SAMPLE_BITS-1]}}, older_s1}) +
	             (prod_s1 >>> FRAC_BITS);

	always_ff @(posedge clk) begin
		v_s2 <= sum[SAMPLE_BITS-1:0];
	end

	// Stage 3: sign and magnitude, magnitude times gain
	assign mag   = v_s2[SAMPLE_BITS-1] ? SAMPLE_BITS'(-v_s2) : SAMPLE_BITS'(v_s2);
	assign mprod = {{GAIN_BITS{1'b0}}, mag} * {{SAMPLE_BITS{1'b0}}, gain};

	always_ff @(posedge clk) begin
		m_s3   <= mprod[MAG_BITS-1:0];
		neg_s3 <= v_s2[SAMPLE_BITS-1];
	end

	// Stage 4: quotient estimate by reciprocal, low by at most one
	assign rprod = {{RECIP_BITS{1'b0}}, m_s3} * {{MAG_BITS{1'b0}}, RECIP};

	always_ff @(posedge clk) begin
		q0_s4  <= rprod[MAG_BITS+RECIP_BITS-1:MAG_BITS];
		m_s4   <= m_s3;
		neg_s4 <= neg_s3;
	end

	// Stage 5: correct the estimate, restore sign, saturate
	assign qm    = {{(MAG_BITS-RECIP_BITS){1'b0}}, q0_s4} * DIV_M;
	assign rem   = m_s4 - qm;
	assign q     = {1'b0, q0_s4} + {{(QB-1){1'b0}}, (rem >= DIV_M)};
	assign q_neg = QB'(0) - q;

	always_ff @(posedge clk) begin
		if (neg_s4) begin
			result <= (q > NEG_MAG) ? S_MIN : q_neg[SAMPLE_BITS-1:0];
		end else begin
			result <= (q > POS_MAX) ? S_MAX : q[SAMPLE_BITS-1:0];
		end
	end

endmodule

`default_nettype wire

/* src/lir_merge.sv */
// Merge stage: combines the left and right lane results with the run flag
// into one output frame register. Depends on lir_pkg.
`default_nettype none

module lir_merge (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lir_pkg::lir_merge_req_t               req,
	input  logic signed [lir_pkg::SAMPLE_BITS-1:0] left,
	input  logic signed [lir_pkg::SAMPLE_BITS-1:0] right,
	output logic                                  free,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output lir_pkg::lir_out_t                     out_data
);
	import lir_pkg::*;

	// Register is free when empty or being taken this cycle
	assign free = !out_valid || !out_stall;

	// Hold the request until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (req.load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	// Capture both lanes and the run flag as one frame
	always_ff @(posedge clk) begin
		if (req.load) begin
			out_data.left_out  <= left;
			out_data.right_out <= right;
			out_data.run_end   <= req.run_end;
		end
	end

endmodule

`default_nettype wire

/* src/linear_interp_stereo_resampler.sv */
// Top level of the stereo linear interpolation resampler: phase sequencer,
// two channel lanes and the merge register. Depends on lir_pkg, lir_lane,
// lir_merge and assert_macros.svh.
//
//   channel | signals                        | accepted when
//   in      | in_valid, in_stall, in_data    | in_valid && !in_stall
//   out     | out_valid, out_stall, out_data | out_valid && !out_stall
//   cfg     | cfg_we, cfg_index, cfg_data    | cfg_we
//
// An input frame is taken only while the sequencer is idle. For each output
// frame it causes, the sequencer lets the five-stage lane pipeline settle
// before loading the merge register; the next frame waits for the run end.
// A stalled output register holds the next result in the lanes until free.
// Reset clears the sequencer at once; no clearing pass is needed.
`default_nettype none

module linear_interp_stereo_resampler #(
	parameter int MAX_RUN = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  lir_pkg::lir_in_t                     in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output lir_pkg::lir_out_t                    out_data,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [lir_pkg::PHASE_BITS-1:0]       cfg_data
);
	import lir_pkg::*;

	localparam int RUN_BITS = $clog2(MAX_RUN + 1);
	localparam int LAT_BITS = $clog2(LANE_LAT + 1);

	lir_state_t state_q, state_d;

	logic [PHASE_BITS-1:0]  step_q;
	logic [GAIN_BITS-1:0]   gain_q;
	logic [1:0]             prime_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic [RUN_BITS-1:0]    run_q;
	logic [LAT_BITS-1:0]    wait_q;
	logic signed [SAMPLE_BITS-1:0] older_l_q, older_r_q, newer_l_q, newer_r_q;

	logic                   accept;
	logic                   deliver;
	logic                   last;
	logic                   start_run;
	logic [PHASE_BITS-1:0]  phase_dec;
	logic [PHASE_BITS-1:0]  start_phase;
	logic [PHASE_BITS:0]    phase_sum;
	logic [PHASE_BITS-1:0]  phase_adv;
	logic [RUN_BITS-1:0]    run_next;
	logic                   merge_free;
	lir_merge_req_t         merge_req;
	logic signed [SAMPLE_BITS-1:0] lane_l, lane_r;

	// Phase arithmetic: drop one whole frame, or advance by step with saturation
	assign phase_dec   = (phase_q >= PHASE_ONE) ? phase_q - PHASE_ONE : '0;
	assign start_phase = (prime_q == 2'd1) ? phase_q : phase_dec;
	assign phase_sum   = {1'b0, phase_q} + {1'b0, step_q};
	assign phase_adv   = phase_sum[PHASE_BITS] ? PHASE_MAX : phase_sum[PHASE_BITS-1:0];
	assign run_next    = run_q + 1'b1;
	assign last        = (run_next == RUN_BITS'(MAX_RUN)) || (phase_adv >= PHASE_ONE);

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign start_run = accept && (prime_q != 2'd0) && (start_phase < PHASE_ONE);
	assign deliver   = (state_q == ST_WAIT) && (wait_q == '0) && merge_free;

	assign merge_req.load    = deliver;
	assign merge_req.run_end = last;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_run) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (deliver && last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RESET;
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PHASE_STEP: step_q <= cfg_data;
				CFG_GAIN:       gain_q <= cfg_data[GAIN_BITS-1:0];
				default:        step_q <= step_q;
			endcase
		end
	end

	// Priming, phase, run count and lane settle timer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= 2'd0;
			phase_q <= '0;
			run_q   <= '0;
			wait_q  <= '0;
		end else begin
			if (accept) begin
				if (prime_q != 2'd2) begin
					prime_q <= prime_q + 2'd1;
				end
				if (prime_q != 2'd0) begin
					phase_q <= start_phase;
				end
				run_q  <= '0;
				wait_q <= LAT_BITS'(LANE_LAT);
			end else if (deliver) begin
				phase_q <= phase_adv;
				run_q   <= run_next;
				wait_q  <= LAT_BITS'(LANE_LAT);
			end else if (wait_q != '0) begin
				wait_q <= wait_q - 1'b1;
			end
		end
	end

	// Frame history: load older, then newer, then shift
	always_ff @(posedge clk) begin
		if (accept) begin
			unique case (prime_q)
				2'd0: begin
					older_l_q <= in_data.left_in;
					older_r_q <= in_data.right_in;
				end
				2'd1: begin
					newer_l_q <= in_data.left_in;
					newer_r_q <= in_data.right_in;
				end
				default: begin
					older_l_q <= newer_l_q;
					older_r_q <= newer_r_q;
					newer_l_q <= in_data.left_in;
					newer_r_q <= in_data.right_in;
				end
			endcase
		end
	end

	lir_lane u_lane_l (
		.clk    (clk),
		.older  (older_l_q),
		.newer  (newer_l_q),
		.frac   (phase_q[PHASE_FRAC_BITS-1 -: FRAC_BITS]),
		.gain   (gain_q),
		.result (lane_l)
	);

	lir_lane u_lane_r (
		.clk    (clk),
		.older  (older_r_q),
		.newer  (newer_r_q),
		.frac   (phase_q[PHASE_FRAC_BITS-1 -: FRAC_BITS]),
		.gain   (gain_q),
		.result (lane_r)
	);

	lir_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (merge_req),
		.left      (lane_l),
		.right     (lane_r),
		.free      (merge_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	`include "assert_macros.svh"

	`LIR_ASSERT_IMPL(a_load_free, merge_req.load, !out_valid || !out_stall, "load into busy output")
	`LIR_ASSERT_IMPL(a_run_cap, 1'b1, run_q <= RUN_BITS'(MAX_RUN), "run count past cap")
	`LIR_ASSERT_NEXT(a_end_idle, merge_req.load && merge_req.run_end, state_q == ST_IDLE, "run end did not return to idle")
	`LIR_ASSERT_NEXT(a_more_follow, merge_req.load && !merge_req.run_end, phase_q < PHASE_ONE, "run continued past phase one")

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the stereo linear interpolation resampler.
// Needs lir_pkg and the resampler RTL; a built-in predictor of phase,
// history and gain checks every output request.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import lir_pkg::*;

	localparam int RUN_CAP       = 64;
	localparam int SETTLE_CYCLES = 2 * (LANE_LAT + 1) + 4;
	localparam int MAX_WAIT      = 12;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PHASE_BITS-1:0] phase_t;

	localparam sample_t S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint  S_HI  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
	localparam longint  S_LO  = -S_HI - 1;
	localparam phase_t  STEP_LOW  = PHASE_ONE >> 6;
	localparam phase_t  STEP_HIGH = PHASE_ONE << 2;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	lir_in_t in_data;
	logic out_valid;
	logic out_stall;
	lir_out_t out_data;
	logic cfg_we;
	logic cfg_index;
	phase_t cfg_data;

	// Predictor state: registers, read phase and frame history
	phase_t step_reg = STEP_RESET;
	logic [GAIN_BITS-1:0] gain_reg = GAIN_RESET;
	int unsigned primed = 0;
	phase_t read_phase = '0;
	sample_t old_l = '0, old_r = '0, new_l = '0, new_r = '0;

	lir_out_t owed_frames[$];

	int unsigned fail_count = 0;
	int unsigned frames_in = 0;
	int unsigned frames_out = 0;
	int unsigned longest_run = 0;

	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int unsigned rx_hold = 0;

	linear_interp_stereo_resampler #(
		.MAX_RUN(RUN_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Interpolate one channel, floor the fraction product, then scale by gain and saturate
	function automatic sample_t lerp_scale(sample_t a, sample_t b,
			logic [FRAC_BITS-1:0] frac, logic [GAIN_BITS-1:0] gain);
		longint diff, v;
		diff = longint'(b) - longint'(a);
		v = longint'(a) + ((diff * longint'(frac)) >>> FRAC_BITS);
		v = (v * longint'(gain)) / GAIN_DIVISOR;
		if (v > S_HI) v = S_HI;
		if (v < S_LO) v = S_LO;
		return sample_t'(v);
	endfunction

	// Advance the predictor by one source frame and queue the outputs it owes
	function automatic void resample_frame(lir_in_t f);
		int n;
		lir_out_t r;
		logic [FRAC_BITS-1:0] frac;
		logic [PHASE_BITS:0] sum;
		if (primed == 0) begin
			old_l = f.left_in;
			old_r = f.right_in;
			primed = 1;
			return;
		end
		if (primed == 1) begin
			new_l = f.left_in;
			new_r = f.right_in;
			primed = 2;
		end else begin
			read_phase = (read_phase >= PHASE_ONE) ? read_phase - PHASE_ONE : '0;
			old_l = new_l;
			old_r = new_r;
			new_l = f.left_in;
			new_r = f.right_in;
		end
		n = 0;
		while (n < RUN_CAP && read_phase < PHASE_ONE) begin
			frac = read_phase[PHASE_FRAC_BITS-1 -: FRAC_BITS];
			r.left_out = lerp_scale(old_l, new_l, frac, gain_reg);
			r.right_out = lerp_scale(old_r, new_r, frac, gain_reg);
			sum = {1'b0, read_phase} + {1'b0, step_reg};
			read_phase = (sum > {1'b0, PHASE_MAX}) ? PHASE_MAX : sum[PHASE_BITS-1:0];
			n++;
			r.run_end = (n == RUN_CAP) || (read_phase >= PHASE_ONE);
			owed_frames.push_back(r);
		end
		if (n > longest_run) longest_run = n;
	endfunction

	function automatic lir_in_t stereo(sample_t l, sample_t r);
		lir_in_t f;
		f.left_in = l;
		f.right_in = r;
		return f;
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 5))
			0: return S_MAX;
			1: return S_MIN;
			2: return sample_t'(int'($urandom_range(0, 16)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offer one frame after a random gap; valid stays high for a following frame
	task automatic send_frame(lir_in_t f);
		int unsigned gap;
		gap = tx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= f;
		do @(posedge clk); while (in_stall);
		frames_in++;
		resample_frame(f);
	endtask

	// Stop offering and wait until every owed output has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		while (owed_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, phase_t value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_PHASE_STEP) step_reg = value;
		else gain_reg = value[GAIN_BITS-1:0];
		@(posedge clk);
	endtask

	// Priming frames and unit step at reset defaults
	task automatic test_priming();
		send_frame(stereo(S_MAX, S_MIN));
		send_frame(stereo(S_MIN, S_MAX));
		send_frame(stereo('0, -1));
		send_frame(stereo(S_MAX, S_MAX));
	endtask

	// Fractional steps with full-scale swings in both directions
	task automatic test_fractions();
		write_reg(CFG_PHASE_STEP, PHASE_ONE >> 2);
		send_frame(stereo(S_MAX, S_MIN));
		send_frame(stereo(S_MIN, S_MAX));
		write_reg(CFG_PHASE_STEP, phase_t'(35'h0_5555_5555));
		send_frame(stereo(-1, 1));
		send_frame(stereo(S_MAX, -3));
	endtask

	// Zero gain, truncation toward zero, and saturation above 100 percent
	task automatic test_gain();
		write_reg(CFG_GAIN, phase_t'(0));
		send_frame(stereo(S_MAX, S_MIN));
		write_reg(CFG_GAIN, phase_t'(127));
		send_frame(stereo(S_MIN, S_MAX));
		send_frame(stereo(S_MAX, S_MIN));
		write_reg(CFG_GAIN, phase_t'(50));
		send_frame(stereo(-3, 3));
		write_reg(CFG_GAIN, phase_t'(101));
		send_frame(stereo(S_MAX, S_MIN));
	endtask

	// Run cap with tiny steps; the phase then floors at zero on the next frame
	task automatic test_run_cap();
		write_reg(CFG_GAIN, phase_t'(GAIN_DIVISOR));
		write_reg(CFG_PHASE_STEP, PHASE_ONE >> 12);
		send_frame(stereo(S_MIN, S_MAX));
		send_frame(stereo(S_MAX, S_MIN));
		write_reg(CFG_PHASE_STEP, STEP_LOW);
		send_frame(stereo(pick_sample(), pick_sample()));
		write_reg(CFG_PHASE_STEP, '0);
		send_frame(stereo(pick_sample(), pick_sample()));
	endtask

	// Saturating phase: most frames give nothing until the phase works down
	task automatic test_phase_saturation();
		write_reg(CFG_PHASE_STEP, PHASE_MAX);
		repeat (8) send_frame(stereo(pick_sample(), pick_sample()));
		write_reg(CFG_PHASE_STEP, STEP_HIGH);
		repeat (2) send_frame(stereo(pick_sample(), pick_sample()));
	endtask

	// Long output hold-off while frames keep coming, then pause the sender
	task automatic test_backpressure();
		write_reg(CFG_PHASE_STEP, PHASE_ONE >> 3);
		tx_idle_on = 1'b0;
		rx_hold = 400;
		repeat (12) send_frame(stereo(pick_sample(), pick_sample()));
		drain_results();
		tx_idle_on = 1'b1;
	endtask

	// Random settings per phase, random frames, random idling on both sides
	task automatic test_random();
		phase_t step;
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 6))
				0: step = STEP_LOW;
				1: step = STEP_HIGH;
				2: step = phase_t'($urandom_range(1 << 20, 1 << 26));
				3: step = PHASE_ONE;
				default: step = (phase_t'($urandom_range(0, 3)) << PHASE_FRAC_BITS)
					| phase_t'($urandom);
			endcase
			if (step < STEP_LOW && p != 2) step = STEP_LOW;
			write_reg(CFG_PHASE_STEP, step);
			write_reg(CFG_GAIN, ($urandom_range(0, 4) != 0)
				? phase_t'($urandom_range(0, 100)) : phase_t'($urandom_range(101, 127)));
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			repeat (30) send_frame(stereo(pick_sample(), pick_sample()));
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	// Output side: random stall before each request, or a long hold on demand
	initial begin : result_sink
		int unsigned pause;
		out_stall <= 1'b1;
		@(posedge arst_n);
		forever begin
			if (rx_hold != 0) begin
				pause = rx_hold;
				rx_hold = 0;
			end else begin
				pause = rx_idle_on ? $urandom_range(0, MAX_WAIT) : 0;
			end
			if (pause != 0) begin
				out_stall <= 1'b1;
				repeat (pause) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic check_field(string name, sample_t want, sample_t got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Compare each accepted output request with the oldest owed frame
	always @(posedge clk) begin : result_check
		lir_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			frames_out++;
			if (owed_frames.size() == 0) begin
				$error("output request with nothing owed: %0d %0d %0d",
					out_data.left_out, out_data.right_out, out_data.run_end);
				fail_count++;
			end else begin
				want = owed_frames.pop_front();
				check_field("left_out", want.left_out, out_data.left_out);
				check_field("right_out", want.right_out, out_data.right_out);
				check_field("run_end", want.run_end, out_data.run_end);
			end
		end
	end

	initial begin : watchdog
		#(15_000_000);
		$display("Some tests failed");
		$finish;
	end

	initial begin : run_tests
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_PHASE_STEP;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_priming();
		test_fractions();
		test_gain();
		test_run_cap();
		test_phase_saturation();
		test_backpressure();
		test_random();
		drain_results();

		$display("Ran %0d source frames, checked %0d output frames, longest run %0d.",
			frames_in, frames_out, longest_run);
		$display("Steps from zero to saturation, gains 0 to 127, with stalls on both sides.");
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* linear_interp_stereo_resampler.f */
+incdir+src
src/lir_pkg.sv
src/lir_lane.sv
src/lir_merge.sv
src/linear_interp_stereo_resampler.sv
test/testbench.sv
